// ===== src/irc_message_tokenizer_macros.svh =====
//------------------------------------------------------------------------------
// IRC message tokenizer assertion macros
// Concurrent assertion wrappers; they compile to nothing when SYNTH is set.
// Users must have clk and rst in scope.
//------------------------------------------------------------------------------
`ifndef IRC_MESSAGE_TOKENIZER_MACROS_SVH
`define IRC_MESSAGE_TOKENIZER_MACROS_SVH

`ifndef SYNTH
`define IRC_MT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("irc tokenizer: implication check failed");
`define IRC_MT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("irc tokenizer: next-cycle check failed");
`else
`define IRC_MT_ASSERT_IMP(lbl, ante, cons)
`define IRC_MT_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== src/irc_mt_pkg.sv =====
//------------------------------------------------------------------------------
// IRC tokenizer package
// Shared types, character codes and result builder.
//------------------------------------------------------------------------------
`default_nettype none

package irc_mt_pkg;

  localparam int MAX_PARAMS = 15;
  localparam int RES_SLOTS  = 5;
  localparam int CNT_W      = $clog2(RES_SLOTS + 1);

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CASE_OFS = 8'h20;
  localparam logic [7:0] RUN_MAX  = 8'hFF;

  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_PREFIX = 3'd1,
    PH_CSKIP  = 3'd2,
    PH_CMD    = 3'd3,
    PH_PSKIP  = 3'd4,
    PH_PARAM  = 3'd5,
    PH_TRAIL  = 3'd6,
    PH_DONE   = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_RUN  = 2'd1,
    KIND_END  = 2'd2,
    KIND_MSG  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    FLD_PREFIX = 2'd0,
    FLD_CMD    = 2'd1,
    FLD_PARAM  = 2'd2
  } field_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } in_item_t;

  typedef struct packed {
    kind_t      kind;
    field_t     field;
    logic [3:0] param_index;
    logic [7:0] data_value;
    logic [7:0] run_length;
    logic       is_trailing;
    logic       overflow;
    logic       malformed;
    logic       last_result;
  } res_t;

  typedef res_t [RES_SLOTS-1:0] batch_t;

  function automatic res_t mk_res(input kind_t k, input field_t f, input logic [3:0] idx,
                                  input logic [7:0] dv, input logic [7:0] rl,
                                  input logic tr, input logic ovf, input logic mal);
    res_t r;
    r.kind        = k;
    r.field       = f;
    r.param_index = idx;
    r.data_value  = dv;
    r.run_length  = rl;
    r.is_trailing = tr;
    r.overflow    = ovf;
    r.malformed   = mal;
    r.last_result = 1'b0;
    return r;
  endfunction

  // index of the open parameter; zero before the first one
  function automatic logic [3:0] cur_idx(input logic [3:0] pc);
    return (pc != 4'd0) ? pc - 4'd1 : 4'd0;
  endfunction

endpackage

`default_nettype wire

// ===== src/irc_mt_inreg.sv =====
//------------------------------------------------------------------------------
// IRC tokenizer input register
// Holds one accepted byte until the parser takes it.
//------------------------------------------------------------------------------
`default_nettype none

module irc_mt_inreg
  import irc_mt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  input  logic       advance,
  output logic       full,
  output in_item_t   item
);

  logic accept;

  assign in_stall = full && !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (accept) begin
      full <= 1'b1;
    end else if (advance) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.data <= data_byte;
      item.last <= last_byte;
    end
  end

endmodule

`default_nettype wire

// ===== src/irc_mt_parser.sv =====
//------------------------------------------------------------------------------
// IRC tokenizer parser
// Message state and the per-byte decode into a batch of up to five results.
//------------------------------------------------------------------------------
`default_nettype none

module irc_mt_parser
  import irc_mt_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  in_item_t         item,
  output batch_t           batch,
  output logic [CNT_W-1:0] batch_count
);

  phase_t     phase, phase_next;
  logic [3:0] param_count, param_count_next;
  logic [7:0] pending_newlines, pending_newlines_next;
  logic       param_open, param_open_next;
  logic       trailing_mode, trailing_mode_next;
  logic       overflow_seen, overflow_seen_next;

  logic [7:0] b;
  logic       is_nl;
  logic       is_colon;
  res_t       cmd_res;
  phase_t     cmd_ph;
  logic       mal;
  batch_t     res;
  logic [CNT_W-1:0] n;

  assign b        = item.data;
  assign is_nl    = (b == CH_CR) || (b == CH_LF);
  assign is_colon = (b == CH_COLON);

  // command byte: a space ends the command, a-z is upper-cased
  always_comb begin
    if (b == CH_SPACE) begin
      cmd_res = mk_res(KIND_END, FLD_CMD, 4'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
      cmd_ph  = PH_PSKIP;
    end else begin
      cmd_res = mk_res(KIND_DATA, FLD_CMD, 4'd0,
                       ((b >= CH_LO_A) && (b <= CH_LO_Z)) ? b - CASE_OFS : b,
                       8'd0, 1'b0, 1'b0, 1'b0);
      cmd_ph  = PH_CMD;
    end
  end

  always_comb begin
    phase_next            = phase;
    param_count_next      = param_count;
    pending_newlines_next = pending_newlines;
    param_open_next       = param_open;
    trailing_mode_next    = trailing_mode;
    overflow_seen_next    = overflow_seen;
    mal                   = 1'b0;
    n                     = '0;
    res                   = '0;

    case (phase)
      PH_START: begin
        if (is_colon) begin
          phase_next = PH_PREFIX;
        end else begin
          res[n] = cmd_res; n = n + 1'b1;
          phase_next = cmd_ph;
        end
      end
      PH_PREFIX: begin
        if (b == CH_SPACE) begin
          res[n] = mk_res(KIND_END, FLD_PREFIX, 4'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
          n = n + 1'b1;
          phase_next = PH_CSKIP;
        end else begin
          res[n] = mk_res(KIND_DATA, FLD_PREFIX, 4'd0, b, 8'd0, 1'b0, 1'b0, 1'b0);
          n = n + 1'b1;
        end
      end
      PH_CSKIP: begin
        if (b != CH_SPACE) begin
          res[n] = cmd_res; n = n + 1'b1;
          phase_next = cmd_ph;
        end
      end
      PH_CMD: begin
        res[n] = cmd_res; n = n + 1'b1;
        phase_next = cmd_ph;
      end
      PH_PSKIP: begin
        if (b != CH_SPACE) begin
          // close the previous parameter; a CR/LF drops its held run
          if (param_open_next) begin
            if (!is_nl && (pending_newlines_next != 8'd0)) begin
              res[n] = mk_res(KIND_RUN, FLD_PARAM, cur_idx(param_count_next), 8'd0,
                              pending_newlines_next, trailing_mode_next, 1'b0, 1'b0);
              n = n + 1'b1;
            end
            pending_newlines_next = 8'd0;
            res[n] = mk_res(KIND_END, FLD_PARAM, cur_idx(param_count_next), 8'd0, 8'd0,
                            trailing_mode_next, 1'b0, 1'b0);
            n = n + 1'b1;
            param_open_next    = 1'b0;
            trailing_mode_next = 1'b0;
          end
          if (is_nl) begin
            phase_next = PH_DONE;
          end else if (param_count_next >= 4'(MAX_PARAMS)) begin
            overflow_seen_next = 1'b1;
            phase_next         = PH_DONE;
          end else begin
            param_count_next      = param_count_next + 4'd1;
            param_open_next       = 1'b1;
            trailing_mode_next    = is_colon;
            pending_newlines_next = 8'd0;
            if (is_colon) begin
              phase_next = PH_TRAIL;
            end else begin
              res[n] = mk_res(KIND_DATA, FLD_PARAM, cur_idx(param_count_next), b, 8'd0,
                              1'b0, 1'b0, 1'b0);
              n = n + 1'b1;
              phase_next = PH_PARAM;
            end
          end
        end
      end
      PH_PARAM, PH_TRAIL: begin
        if ((phase == PH_PARAM) && (b == CH_SPACE)) begin
          phase_next = PH_PSKIP;
        end else if (b == CH_LF) begin
          if (pending_newlines == RUN_MAX) begin
            overflow_seen_next = 1'b1;
          end else begin
            pending_newlines_next = pending_newlines + 8'd1;
          end
        end else begin
          if (pending_newlines != 8'd0) begin
            res[n] = mk_res(KIND_RUN, FLD_PARAM, cur_idx(param_count), 8'd0,
                            pending_newlines, trailing_mode, 1'b0, 1'b0);
            n = n + 1'b1;
            pending_newlines_next = 8'd0;
          end
          res[n] = mk_res(KIND_DATA, FLD_PARAM, cur_idx(param_count), b, 8'd0,
                          (phase == PH_TRAIL), 1'b0, 1'b0);
          n = n + 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (item.last) begin
      case (phase_next)
        PH_PREFIX: mal = 1'b1;
        PH_START, PH_CSKIP, PH_CMD: begin
          res[n] = mk_res(KIND_END, FLD_CMD, 4'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
          n = n + 1'b1;
        end
        PH_PSKIP, PH_PARAM, PH_TRAIL: begin
          // held run at the end of the last parameter is dropped
          if (param_open_next) begin
            res[n] = mk_res(KIND_END, FLD_PARAM, cur_idx(param_count_next), 8'd0, 8'd0,
                            trailing_mode_next, 1'b0, 1'b0);
            n = n + 1'b1;
          end
        end
        default: begin
        end
      endcase
      res[n] = mk_res(KIND_MSG, FLD_PREFIX, 4'd0, 8'd0, 8'd0, 1'b0,
                      overflow_seen_next, mal);
      n = n + 1'b1;
      phase_next            = PH_START;
      param_count_next      = 4'd0;
      pending_newlines_next = 8'd0;
      param_open_next       = 1'b0;
      trailing_mode_next    = 1'b0;
      overflow_seen_next    = 1'b0;
    end

    if (n != '0) begin
      res[n - 1'b1].last_result = 1'b1;
    end
  end

  assign batch       = res;
  assign batch_count = n;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_START;
      param_count      <= 4'd0;
      pending_newlines <= 8'd0;
      param_open       <= 1'b0;
      trailing_mode    <= 1'b0;
      overflow_seen    <= 1'b0;
    end else if (advance) begin
      phase            <= phase_next;
      param_count      <= param_count_next;
      pending_newlines <= pending_newlines_next;
      param_open       <= param_open_next;
      trailing_mode    <= trailing_mode_next;
      overflow_seen    <= overflow_seen_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/irc_mt_outbuf.sv =====
//------------------------------------------------------------------------------
// IRC tokenizer result buffer
// Five-slot shift buffer that hands out one result per cycle while out_stall is low.
//------------------------------------------------------------------------------
`default_nettype none

module irc_mt_outbuf
  import irc_mt_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  batch_t           batch,
  input  logic [CNT_W-1:0] batch_count,
  output logic             load_ok,
  output logic             out_valid,
  input  logic             out_stall,
  output res_t             head
);

  batch_t           slots;
  logic [CNT_W-1:0] rem;
  logic             take;

  assign out_valid = (rem != '0);
  assign take      = out_valid && !out_stall;
  // a new batch may land as the last queued result leaves
  assign load_ok   = (rem == '0) || ((rem == CNT_W'(1)) && take);
  assign head      = slots[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
    end else if (advance) begin
      rem <= batch_count;
    end else if (take) begin
      rem <= rem - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      slots <= batch;
    end else if (take) begin
      for (int i = 0; i < RES_SLOTS - 1; i++) begin
        slots[i] <= slots[i + 1];
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/irc_message_tokenizer.sv =====
// IRC message tokenizer: takes one message byte per cycle unless stalled and tags it as
// prefix, command or parameter, giving data, newline-run, token-end and message-end
// results. A byte is accepted every cycle as long as results drain; a byte yields
// zero to five results, and results leave one per cycle from a five-slot buffer
// unless out_stall holds them, so the input stalls behind a byte with more than one
// result while the output is busy. A byte passes through the input register, then
// the decode into the result buffer, before its first result appears.
//------------------------------------------------------------------------------
// IRC message tokenizer top level
// Input register, byte decode with message state, and result buffer.
//------------------------------------------------------------------------------
`default_nettype none

`include "irc_message_tokenizer_macros.svh"

module irc_message_tokenizer
  import irc_mt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] kind,
  output logic [1:0] field,
  output logic [3:0] param_index,
  output logic [7:0] data_value,
  output logic [7:0] run_length,
  output logic       is_trailing,
  output logic       overflow,
  output logic       malformed,
  output logic       last_result
);

  in_item_t         item;
  logic             full;
  logic             load_ok;
  logic             advance;
  batch_t           batch;
  logic [CNT_W-1:0] batch_count;
  res_t             head;

  assign advance = full && load_ok;

  irc_mt_inreg u_inreg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .advance   (advance),
    .full      (full),
    .item      (item)
  );

  irc_mt_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .item        (item),
    .batch       (batch),
    .batch_count (batch_count)
  );

  irc_mt_outbuf u_outbuf (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .batch       (batch),
    .batch_count (batch_count),
    .load_ok     (load_ok),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .head        (head)
  );

  assign kind        = head.kind;
  assign field       = head.field;
  assign param_index = head.param_index;
  assign data_value  = head.data_value;
  assign run_length  = head.run_length;
  assign is_trailing = head.is_trailing;
  assign overflow    = head.overflow;
  assign malformed   = head.malformed;
  assign last_result = head.last_result;

  `IRC_MT_ASSERT_IMP(a_msg_end_is_last, out_valid && (kind == KIND_MSG), last_result)
  `IRC_MT_ASSERT_IMP(a_flags_only_on_msg, out_valid && (kind != KIND_MSG), !overflow && !malformed)
  `IRC_MT_ASSERT_IMP(a_run_nonzero, out_valid && (kind == KIND_RUN), run_length != 8'd0)
  `IRC_MT_ASSERT_IMP(a_index_param_only, out_valid && (field != FLD_PARAM), (param_index == 4'd0) && !is_trailing)

endmodule

`default_nettype wire

// ===== bench/tb_irc_message_tokenizer.sv =====
//------------------------------------------------------------------------------
// IRC message tokenizer testbench
// Feeds whole messages a byte at a time, predicts the tagged result stream
// and checks every result in order, under random and forced backpressure.
//------------------------------------------------------------------------------
module tb_irc_message_tokenizer;
  import irc_mt_pkg::*;

  localparam int HOLD_CYCLES = 60;
  localparam int QUIET_LIMIT = 4000;
  localparam int SHOWN_ERRORS = 10;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] data_byte = 8'd0;
  logic       last_byte = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] kind;
  logic [1:0] field;
  logic [3:0] param_index;
  logic [7:0] data_value;
  logic [7:0] run_length;
  logic       is_trailing;
  logic       overflow;
  logic       malformed;
  logic       last_result;

  irc_message_tokenizer i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .last_byte   (last_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .field       (field),
    .param_index (param_index),
    .data_value  (data_value),
    .run_length  (run_length),
    .is_trailing (is_trailing),
    .overflow    (overflow),
    .malformed   (malformed),
    .last_result (last_result)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // tokenizer state as predicted
  phase_t     tk_phase = PH_START;
  logic [3:0] tk_params = 4'd0;
  logic [7:0] tk_newlines = 8'd0;
  logic       tk_open = 1'b0;
  logic       tk_trail = 1'b0;
  logic       tk_ovf = 1'b0;

  res_t       byte_res[$];
  res_t       expected_results[$];
  in_item_t   byte_queue[$];
  in_item_t   next_item;
  logic [7:0] msg[$];

  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet = 0;
  int errors = 0;
  int bytes_in = 0;
  int results_seen = 0;
  int msgs_seen = 0;
  int ovf_ends = 0;
  int mal_ends = 0;

  function automatic void tk_clear();
    tk_phase = PH_START;
    tk_params = 4'd0;
    tk_newlines = 8'd0;
    tk_open = 1'b0;
    tk_trail = 1'b0;
    tk_ovf = 1'b0;
  endfunction

  function automatic logic [3:0] open_slot();
    return (tk_params == 4'd0) ? 4'd0 : tk_params - 4'd1;
  endfunction

  function automatic void add_res(input kind_t k, input field_t f, input logic [3:0] idx,
                                  input logic [7:0] dv, input logic [7:0] rl,
                                  input logic tr, input logic ov, input logic ml);
    res_t r;
    r.kind = k;
    r.field = f;
    r.param_index = idx;
    r.data_value = dv;
    r.run_length = rl;
    r.is_trailing = tr;
    r.overflow = ov;
    r.malformed = ml;
    r.last_result = 1'b0;
    byte_res = {byte_res, r};
  endfunction

  function automatic void flush_newlines();
    if (tk_newlines != 8'd0) begin
      add_res(KIND_RUN, FLD_PARAM, open_slot(), 8'd0, tk_newlines, tk_trail, 1'b0, 1'b0);
      tk_newlines = 8'd0;
    end
  endfunction

  function automatic void hold_newline();
    if (tk_newlines == RUN_MAX)
      tk_ovf = 1'b1;
    else
      tk_newlines++;
  endfunction

  function automatic void close_param(input logic keep_run);
    if (!tk_open)
      return;
    if (keep_run)
      flush_newlines();
    tk_newlines = 8'd0;
    add_res(KIND_END, FLD_PARAM, open_slot(), 8'd0, 8'd0, tk_trail, 1'b0, 1'b0);
    tk_open = 1'b0;
    tk_trail = 1'b0;
  endfunction

  function automatic logic open_param(input logic trailing);
    if (tk_params >= MAX_PARAMS) begin
      // excess parameter: the rest of the message is ignored
      tk_ovf = 1'b1;
      tk_phase = PH_DONE;
      return 1'b0;
    end
    tk_params++;
    tk_open = 1'b1;
    tk_trail = trailing;
    tk_newlines = 8'd0;
    return 1'b1;
  endfunction

  function automatic void command_char(input logic [7:0] b);
    logic [7:0] c;
    c = b;
    if (b == CH_SPACE) begin
      add_res(KIND_END, FLD_CMD, 4'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
      tk_phase = PH_PSKIP;
    end else begin
      if (b >= CH_LO_A && b <= CH_LO_Z)
        c = b - CASE_OFS;
      add_res(KIND_DATA, FLD_CMD, 4'd0, c, 8'd0, 1'b0, 1'b0, 1'b0);
      tk_phase = PH_CMD;
    end
  endfunction

  function automatic void predict_byte(input logic [7:0] b, input logic fin);
    logic mal;
    mal = 1'b0;
    byte_res.delete();
    case (tk_phase)
      PH_START: begin
        if (b == CH_COLON)
          tk_phase = PH_PREFIX;
        else
          command_char(b);
      end
      PH_PREFIX: begin
        if (b == CH_SPACE) begin
          add_res(KIND_END, FLD_PREFIX, 4'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
          tk_phase = PH_CSKIP;
        end else begin
          add_res(KIND_DATA, FLD_PREFIX, 4'd0, b, 8'd0, 1'b0, 1'b0, 1'b0);
        end
      end
      PH_CSKIP: begin
        if (b != CH_SPACE)
          command_char(b);
      end
      PH_CMD: command_char(b);
      PH_PSKIP: begin
        if (b == CH_CR || b == CH_LF) begin
          close_param(1'b0);
          tk_phase = PH_DONE;
        end else if (b == CH_COLON) begin
          close_param(1'b1);
          if (open_param(1'b1))
            tk_phase = PH_TRAIL;
        end else if (b != CH_SPACE) begin
          close_param(1'b1);
          if (open_param(1'b0)) begin
            add_res(KIND_DATA, FLD_PARAM, open_slot(), b, 8'd0, 1'b0, 1'b0, 1'b0);
            tk_phase = PH_PARAM;
          end
        end
      end
      PH_PARAM: begin
        if (b == CH_SPACE) begin
          tk_phase = PH_PSKIP;
        end else if (b == CH_LF) begin
          hold_newline();
        end else begin
          flush_newlines();
          add_res(KIND_DATA, FLD_PARAM, open_slot(), b, 8'd0, 1'b0, 1'b0, 1'b0);
        end
      end
      PH_TRAIL: begin
        if (b == CH_LF) begin
          hold_newline();
        end else begin
          flush_newlines();
          add_res(KIND_DATA, FLD_PARAM, open_slot(), b, 8'd0, 1'b1, 1'b0, 1'b0);
        end
      end
      default: ;
    endcase

    if (fin) begin
      case (tk_phase)
        PH_PREFIX: mal = 1'b1;
        PH_START, PH_CSKIP, PH_CMD:
          add_res(KIND_END, FLD_CMD, 4'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
        PH_PSKIP, PH_PARAM, PH_TRAIL: close_param(1'b0);
        default: ;
      endcase
      add_res(KIND_MSG, FLD_PREFIX, 4'd0, 8'd0, 8'd0, 1'b0, tk_ovf, mal);
      tk_clear();
    end

    if (byte_res.size() != 0)
      byte_res[byte_res.size() - 1].last_result = 1'b1;
    expected_results = {expected_results, byte_res};
  endfunction

  function automatic string show_res(input res_t r);
    return $sformatf("kind %0d field %0d idx %0d data %02h run %0d trail %0b ovf %0b mal %0b last %0b",
                     r.kind, r.field, r.param_index, r.data_value, r.run_length,
                     r.is_trailing, r.overflow, r.malformed, r.last_result);
  endfunction

  function automatic void report_error(input string s);
    errors++;
    if (errors <= SHOWN_ERRORS)
      $display("ERROR: %s", s);
  endfunction

  function automatic void check_result();
    res_t got;
    res_t want;
    got.kind = kind_t'(kind);
    got.field = field_t'(field);
    got.param_index = param_index;
    got.data_value = data_value;
    got.run_length = run_length;
    got.is_trailing = is_trailing;
    got.overflow = overflow;
    got.malformed = malformed;
    got.last_result = last_result;
    results_seen++;
    if (got.kind == KIND_MSG) begin
      msgs_seen++;
      if (got.overflow) ovf_ends++;
      if (got.malformed) mal_ends++;
    end
    if (expected_results.size() == 0) begin
      report_error({"unexpected result: ", show_res(got)});
      return;
    end
    want = expected_results.pop_front();
    if (got.kind != want.kind || got.field != want.field ||
        got.param_index != want.param_index || got.data_value != want.data_value ||
        got.run_length != want.run_length || got.is_trailing != want.is_trailing ||
        got.overflow != want.overflow || got.malformed != want.malformed ||
        got.last_result != want.last_result)
      report_error({"expected ", show_res(want), " | got ", show_res(got)});
  endfunction

  // sender
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      data_byte <= 8'd0;
      last_byte <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_byte(data_byte, last_byte);
        bytes_in++;
      end
      if (!in_valid || !in_stall) begin
        if (byte_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_item = byte_queue.pop_front();
          data_byte <= next_item.data;
          last_byte <= next_item.last;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall)
        check_result();
      if (hold_seen != hold_asks) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet = 0;
      else
        quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
        $display("tb_irc_message_tokenizer: errors");
        $finish;
      end
    end
  end

  function automatic logic [7:0] word_char();
    logic [7:0] c;
    case ($urandom_range(0, 7))
      0, 1, 2: c = CH_LO_A + 8'($urandom_range(0, 25));
      3, 4:    c = CH_LO_A - CASE_OFS + 8'($urandom_range(0, 25));
      5:       c = 8'h30 + 8'($urandom_range(0, 9));
      6:       c = 8'($urandom_range(128, 255));
      default: c = 8'($urandom_range(33, 126));
    endcase
    return c;
  endfunction

  function automatic logic [7:0] param_char();
    case ($urandom_range(0, 11))
      0, 1:    return CH_LF;
      2:       return CH_CR;
      default: return word_char();
    endcase
  endfunction

  function automatic logic [7:0] trail_char();
    case ($urandom_range(0, 7))
      0, 1:    return CH_LF;
      2:       return CH_SPACE;
      3:       return CH_COLON;
      default: return word_char();
    endcase
  endfunction

  function automatic void add_byte(input logic [7:0] c);
    msg = {msg, c};
  endfunction

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++)
      add_byte(s[i]);
  endfunction

  function automatic int queue_message();
    in_item_t it;
    int n;
    n = msg.size();
    foreach (msg[i]) begin
      it.data = msg[i];
      it.last = (i == n - 1);
      byte_queue = {byte_queue, it};
    end
    msg.delete();
    return n;
  endfunction

  // shape: below 12 raw noise, below 17 unclosed prefix, 17 one parameter too many,
  // below 25 near the parameter limit, otherwise an ordinary message
  function automatic void build_message(input int shape);
    int np;
    msg.delete();
    if (shape < 12) begin
      repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(0, 255)));
    end else if (shape < 17) begin
      add_byte(CH_COLON);
      repeat ($urandom_range(0, 4)) add_byte(word_char());
    end else begin
      if (shape == 17)
        np = MAX_PARAMS + 1;
      else if (shape < 25)
        np = $urandom_range(MAX_PARAMS - 1, MAX_PARAMS + 2);
      else
        np = $urandom_range(0, 4);
      if ($urandom_range(0, 1)) begin
        add_byte(CH_COLON);
        repeat ($urandom_range(1, 4)) add_byte(word_char());
        repeat ($urandom_range(1, 2)) add_byte(CH_SPACE);
      end
      if ($urandom_range(0, 19) != 0)
        repeat ($urandom_range(1, 4)) add_byte(word_char());
      for (int i = 0; i < np; i++) begin
        repeat ($urandom_range(1, 3)) add_byte(CH_SPACE);
        if (i == np - 1 && $urandom_range(0, 2) == 0) begin
          add_byte(CH_COLON);
          repeat ($urandom_range(0, 6)) add_byte(trail_char());
        end else if (np > 4) begin
          add_byte(word_char());
        end else begin
          repeat ($urandom_range(1, 3)) add_byte(param_char());
        end
      end
      case ($urandom_range(0, 3))
        0: begin
          add_byte(CH_CR);
          add_byte(CH_LF);
        end
        1: add_byte(CH_LF);
        default: ;
      endcase
    end
    if (msg.size() == 0)
      add_byte(word_char());
  endfunction

  function automatic void queue_random(input int count);
    int added;
    added = 0;
    while (added < count) begin
      build_message($urandom_range(0, 99));
      added += queue_message();
    end
  endfunction

  task automatic wait_drained();
    while (byte_queue.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    send_idle_pct = 30;
    stall_pct = 79;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // prefix, lower-case command, 0xFF param, trailing with held and dropped newlines
    add_text(":P a ");
    add_byte(8'hFF);
    add_text(" :y");
    add_byte(CH_LF);
    add_byte(8'h00);
    add_byte(CH_LF);
    void'(queue_message());
    // empty command, both ways
    add_text(" ");
    void'(queue_message());
    add_text(":x ");
    void'(queue_message());
    // ends inside the prefix
    add_text(":ab");
    void'(queue_message());
    // CR opening a parameter ends parsing
    add_text("z ");
    add_byte(CH_CR);
    add_text("q");
    void'(queue_message());
    // held newline kept when another parameter follows
    add_text("k a");
    add_byte(CH_LF);
    add_text(" b");
    void'(queue_message());

    queue_random(50);
    wait_drained();

    send_idle_pct = 79;
    stall_pct = 30;
    queue_random(50);
    wait_drained();

    send_idle_pct = 0;
    stall_pct = 0;
    // parameter overflow while the receiver holds off and the input backs up
    build_message(17);
    void'(queue_message());
    hold_asks++;
    wait_drained();

    queue_random(30);
    wait_drained();
    repeat (8) @(negedge clk);

    if (expected_results.size() != 0) begin
      errors += expected_results.size();
      $display("ERROR: %0d expected results never arrived", expected_results.size());
    end
    $display("run covered %0d bytes in %0d messages, %0d results compared",
             bytes_in, msgs_seen, results_seen);
    $display("message ends with overflow %0d, malformed %0d; mismatches %0d",
             ovf_ends, mal_ends, errors);
    if (errors == 0)
      $display("tb_irc_message_tokenizer: clean");
    else
      $display("tb_irc_message_tokenizer: errors");
    $finish;
  end

endmodule
